>>> src/linked_block_channel_fifo_unit_defines.svh
// assertion helpers for the linked block channel fifo
`ifndef LINKED_BLOCK_CHANNEL_FIFO_UNIT_DEFINES_SVH
`define LINKED_BLOCK_CHANNEL_FIFO_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LBCF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LBCF_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LBCF_ASSERT(label, clk, rst_n, prop, msg)
`define LBCF_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> src/lbcf_pkg.sv
package lbcf_pkg;
    localparam int BLOCK_BYTES  = 16;
    localparam int NUM_BLOCKS   = 32;
    localparam int NUM_CHANNELS = 4;
    localparam int PEEK_MAX     = 16;
    localparam int MAX_RESULTS  = 16;
    localparam int POOL_BYTES   = NUM_BLOCKS * BLOCK_BYTES;
    localparam int AW = $clog2(POOL_BYTES);
    localparam int OW = $clog2(BLOCK_BYTES);
    localparam int BW = $clog2(NUM_BLOCKS);
    localparam int CW = 2;

    localparam logic [1:0] CMD_INIT = 2'd0;
    localparam logic [1:0] CMD_PUT  = 2'd1;
    localparam logic [1:0] CMD_GET  = 2'd2;
    localparam logic [1:0] CMD_PEEK = 2'd3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_LIMIT  = 3'd1;
    localparam logic [2:0] ST_POOL   = 3'd2;
    localparam logic [2:0] ST_EMPTY  = 3'd3;
    localparam logic [2:0] ST_BROKEN = 3'd4;

    localparam logic [7:0] LINK_INVALID = 8'hFF;

    // controller to datapath
    typedef struct packed {
        logic       load;       // capture input item
        logic       mem_rd;     // read pool at address
        logic [1:0] asel;       // 0 rd ptr, 1 wr ptr, 2 new block link, 3 cursor
        logic       mem_wr;
        logic [1:0] wsel;       // 0 data byte, 1 link invalid, 2 new block number
        logic       do_init;
        logic       put_first;  // claim first block
        logic       put_link;   // claim next block
        logic       put_byte;
        logic       get_step;   // follow link
        logic       get_byte;
        logic       get_broken;
        logic       cur_start;
        logic       cur_link;
        logic       cur_step;
    } t_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic       ch_valid;
        logic       over_limit;
        logic       cnt_zero;
        logic       free_any;
        logic       wr_at_link;
        logic       rd_at_link;
        logic       rd_link_bad;   // pool data as link invalid
        logic       cur_at_link;
        logic       cur_end;
        logic       cur_done;      // peek count reached
        logic       want_zero;
        logic       last_byte;     // count equals one
    } t_sts;
endpackage

>>> src/lbcf_datapath.sv
`include "linked_block_channel_fifo_unit_defines.svh"
module lbcf_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lbcf_pkg::t_cmd      i_cmd,
    output lbcf_pkg::t_sts      o_sts,
    input  logic [1:0]          i_command,
    input  logic [1:0]          i_channel,
    input  logic [7:0]          i_data_in,
    input  logic [15:0]         i_limit,
    input  logic [4:0]          i_peek_count,
    output logic [7:0]          o_rd_data,
    output logic [4:0]          o_peek_n
);
    import lbcf_pkg::*;

    logic [7:0]  r_pool [POOL_BYTES];
    logic [7:0]  r_rdata;
    logic [1:0]  r_command;
    logic [CW-1:0] r_ch;
    logic [7:0]  r_byte;
    logic [15:0] r_lim;
    logic [4:0]  r_want;
    logic [NUM_BLOCKS-1:0] r_free;
    logic [AW-1:0] r_wp [NUM_CHANNELS];
    logic [AW-1:0] r_rp [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_pv;
    logic [15:0] r_cnt [NUM_CHANNELS];
    logic [15:0] r_limv [NUM_CHANNELS];
    logic [AW-1:0] r_cur;
    logic [4:0]  r_n;
    logic [BW-1:0] r_newblk;

    logic [BW-1:0] low_free;
    logic [AW-1:0] addr, wp, rp, nb_addr, lk_addr;
    logic [7:0]  wdata;
    logic [4:0]  want_cap;
    logic [BW-1:0] rp_blk;

    assign wp = r_wp[r_ch];
    assign rp = r_rp[r_ch];
    assign rp_blk = rp[AW-1:OW];
    assign nb_addr = {low_free, {OW{1'b0}}};
    assign lk_addr = {r_rdata[BW-1:0], {OW{1'b0}}};

    always_comb begin
        low_free = '0;
        for (int b = NUM_BLOCKS - 1; b >= 0; b--) begin
            if (r_free[b]) low_free = BW'(b);
        end
    end

    always_comb begin
        case (i_cmd.asel)
            2'd0:    addr = rp;
            2'd1:    addr = wp;
            2'd2:    addr = {r_newblk, {OW{1'b1}}};
            default: addr = r_cur;
        endcase
        case (i_cmd.wsel)
            2'd0:    wdata = r_byte;
            2'd1:    wdata = LINK_INVALID;
            default: wdata = 8'(low_free);
        endcase
        want_cap = (r_want > 5'(PEEK_MAX)) ? 5'(PEEK_MAX) : r_want;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) r_pool[addr] <= wdata;
        if (i_cmd.mem_rd) r_rdata <= r_pool[addr];
        if (i_cmd.load) begin
            r_command <= i_command;
            r_ch      <= i_channel;
            r_byte    <= i_data_in;
            r_lim     <= i_limit;
            r_want    <= i_peek_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '1;
            r_pv   <= '0;
            r_n    <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_cnt[c]  <= '0;
                r_limv[c] <= 16'hFFFF;
                r_wp[c]   <= '0;
                r_rp[c]   <= '0;
            end
        end else begin
            if (i_cmd.do_init) begin
                r_pv[r_ch]  <= 1'b0;
                r_cnt[r_ch] <= '0;
                r_wp[r_ch]  <= '0;
                r_rp[r_ch]  <= '0;
                if (r_lim != 16'd0) r_limv[r_ch] <= r_lim;
            end
            if (i_cmd.put_first) begin
                r_free[low_free] <= 1'b0;
                r_newblk <= low_free;
                r_pv[r_ch] <= 1'b1;
                r_wp[r_ch] <= nb_addr;
                r_rp[r_ch] <= nb_addr;
            end
            if (i_cmd.put_link) begin
                r_free[low_free] <= 1'b0;
                r_newblk <= low_free;
                r_wp[r_ch] <= nb_addr;
            end
            if (i_cmd.put_byte) begin
                r_wp[r_ch]  <= wp + AW'(1);
                r_cnt[r_ch] <= r_cnt[r_ch] + 16'd1;
            end
            if (i_cmd.get_step) begin
                r_free[rp_blk] <= 1'b1;
                r_rp[r_ch] <= lk_addr;
            end
            if (i_cmd.get_byte) begin
                if (r_cnt[r_ch] == 16'd1) begin
                    r_free[BW'((rp + AW'(1)) >> OW)] <= 1'b1;
                    r_pv[r_ch]  <= 1'b0;
                    r_cnt[r_ch] <= '0;
                    r_wp[r_ch]  <= '0;
                    r_rp[r_ch]  <= '0;
                end else begin
                    r_rp[r_ch]  <= rp + AW'(1);
                    r_cnt[r_ch] <= r_cnt[r_ch] - 16'd1;
                end
            end
            if (i_cmd.get_broken) begin
                // a bad link still hands back the block that held it
                if (r_pv[r_ch]) r_free[rp_blk] <= 1'b1;
                r_pv[r_ch]  <= 1'b0;
                r_cnt[r_ch] <= '0;
                r_wp[r_ch]  <= '0;
                r_rp[r_ch]  <= '0;
            end
            if (i_cmd.cur_start) begin
                r_cur <= rp;
                r_n   <= '0;
            end
            if (i_cmd.cur_link) r_cur <= lk_addr;
            if (i_cmd.cur_step) begin
                r_cur <= r_cur + AW'(1);
                r_n   <= r_n + 5'd1;
            end
        end
    end

    always_comb begin
        o_sts.command     = r_command;
        o_sts.ch_valid    = r_pv[r_ch];
        o_sts.over_limit  = (r_cnt[r_ch] > r_limv[r_ch]) || (r_cnt[r_ch] == 16'hFFFF);
        o_sts.cnt_zero    = (r_cnt[r_ch] == 16'd0);
        o_sts.free_any    = |r_free;
        o_sts.wr_at_link  = (wp[OW-1:0] == {OW{1'b1}});
        o_sts.rd_at_link  = (rp[OW-1:0] == {OW{1'b1}});
        o_sts.rd_link_bad = (r_rdata >= 8'(NUM_BLOCKS));
        o_sts.cur_at_link = (r_cur[OW-1:0] == {OW{1'b1}});
        o_sts.cur_end     = (r_cur == wp);
        o_sts.cur_done    = (r_n >= want_cap);
        o_sts.want_zero   = (want_cap == 5'd0);
        o_sts.last_byte   = (r_cnt[r_ch] == 16'd1);
    end

    assign o_rd_data = r_rdata;
    assign o_peek_n  = r_n;

    `LBCF_ASSERT(a_no_double_claim, i_clk, i_rst_n,
        !(i_cmd.put_first && i_cmd.put_link), "two claims")
    `LBCF_ASSERT(a_claim_free, i_clk, i_rst_n,
        (i_cmd.put_first || i_cmd.put_link) |-> (|r_free), "claim with no free block")
    `LBCF_ASSERT(a_get_nonempty, i_clk, i_rst_n,
        i_cmd.get_byte |-> (r_cnt[r_ch] != 16'd0), "get on empty channel")
endmodule

>>> src/lbcf_ctrl.sv
`include "linked_block_channel_fifo_unit_defines.svh"
module lbcf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [2:0]      o_status,
    output logic [7:0]      o_data_out,
    output logic            o_last,
    output lbcf_pkg::t_cmd  o_cmd,
    input  lbcf_pkg::t_sts  i_sts,
    input  logic [7:0]      i_rd_data
);
    import lbcf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_PUT_NEW, S_PUT_LINKW, S_PUT_BYTE,
        S_GET_RD, S_GET_LINK, S_GET_DATA, S_PK_CHK, S_PK_LINK, S_PK_DATA, S_OUT
    } t_state;

    t_state r_state;
    logic       r_ov;
    logic [2:0] r_status;
    logic [7:0] r_data;
    logic       r_last;
    logic       r_pk_more;
    logic [7:0] r_pk_byte;
    logic       out_free;

    assign out_free = !r_ov || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_ov;
    assign o_status = r_status;
    assign o_data_out = r_data;
    assign o_last   = r_last;

    always_comb begin
        o_cmd = '0;
        o_cmd.load = (r_state == S_IDLE) && i_valid;
        case (r_state)
            S_DISPATCH: begin
                if (out_free) begin
                    case (i_sts.command)
                        CMD_INIT: o_cmd.do_init = 1'b1;
                        CMD_PUT: begin
                            if (!i_sts.over_limit && !i_sts.ch_valid && i_sts.free_any)
                                o_cmd.put_first = 1'b1;
                        end
                        CMD_GET: begin
                            if (!i_sts.cnt_zero && !i_sts.ch_valid)
                                o_cmd.get_broken = 1'b1;
                        end
                        default: o_cmd.cur_start = 1'b1;
                    endcase
                end
            end
            S_PUT_NEW: begin
                // write invalid link of claimed block
                o_cmd.mem_wr = 1'b1;
                o_cmd.asel   = 2'd2;
                o_cmd.wsel   = 2'd1;
            end
            S_PUT_LINKW: begin
                // link cell of full block gets new block number, which is claimed in the same cycle
                o_cmd.mem_wr   = 1'b1;
                o_cmd.asel     = 2'd1;
                o_cmd.wsel     = 2'd2;
                o_cmd.put_link = 1'b1;
            end
            S_PUT_BYTE: begin
                if (out_free) begin
                    o_cmd.mem_wr   = 1'b1;
                    o_cmd.asel     = 2'd1;
                    o_cmd.wsel     = 2'd0;
                    o_cmd.put_byte = 1'b1;
                end
            end
            S_GET_RD: begin
                o_cmd.mem_rd = 1'b1;
                o_cmd.asel   = 2'd0;
            end
            S_GET_LINK: begin
                if (!i_sts.rd_link_bad) o_cmd.get_step = 1'b1;
                else if (out_free) begin
                    o_cmd.get_step   = 1'b0;
                    o_cmd.get_broken = 1'b1;
                end
            end
            S_GET_DATA: begin
                if (out_free) o_cmd.get_byte = 1'b1;
            end
            S_PK_CHK: begin
                o_cmd.mem_rd = 1'b1;
                o_cmd.asel   = 2'd3;
            end
            S_PK_LINK: begin
                if (!i_sts.rd_link_bad) o_cmd.cur_link = 1'b1;
            end
            S_PK_DATA: begin
                if (out_free) o_cmd.cur_step = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ov      <= 1'b0;
            r_pk_more <= 1'b0;
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid) r_state <= S_DISPATCH;
                S_DISPATCH: begin
                    if (out_free) begin
                        case (i_sts.command)
                            CMD_INIT: begin
                                r_ov <= 1'b1; r_status <= ST_OK; r_data <= '0;
                                r_last <= 1'b1; r_state <= S_IDLE;
                            end
                            CMD_PUT: begin
                                if (i_sts.over_limit) begin
                                    r_ov <= 1'b1; r_status <= ST_LIMIT; r_data <= '0;
                                    r_last <= 1'b1; r_state <= S_IDLE;
                                end else if (!i_sts.ch_valid) begin
                                    if (!i_sts.free_any) begin
                                        r_ov <= 1'b1; r_status <= ST_POOL; r_data <= '0;
                                        r_last <= 1'b1; r_state <= S_IDLE;
                                    end else r_state <= S_PUT_NEW;
                                end else if (i_sts.wr_at_link) begin
                                    if (!i_sts.free_any) begin
                                        r_ov <= 1'b1; r_status <= ST_POOL; r_data <= '0;
                                        r_last <= 1'b1; r_state <= S_IDLE;
                                    end else r_state <= S_PUT_LINKW;
                                end else r_state <= S_PUT_BYTE;
                            end
                            CMD_GET: begin
                                if (i_sts.cnt_zero) begin
                                    r_ov <= 1'b1; r_status <= ST_EMPTY; r_data <= '0;
                                    r_last <= 1'b1; r_state <= S_IDLE;
                                end else if (!i_sts.ch_valid) begin
                                    r_ov <= 1'b1; r_status <= ST_BROKEN; r_data <= '0;
                                    r_last <= 1'b1; r_state <= S_IDLE;
                                end else r_state <= S_GET_RD;
                            end
                            default: r_state <= S_PK_CHK;
                        endcase
                    end
                end
                // fresh block: link invalid, then a data byte unless write is at link
                S_PUT_NEW: r_state <= i_sts.wr_at_link ? S_PUT_LINKW : S_PUT_BYTE;
                S_PUT_LINKW: r_state <= S_PUT_NEW;
                S_PUT_BYTE: begin
                    if (out_free) begin
                        r_ov <= 1'b1; r_status <= ST_OK; r_data <= '0;
                        r_last <= 1'b1; r_state <= S_IDLE;
                    end
                end
                S_GET_RD: r_state <= i_sts.rd_at_link ? S_GET_LINK : S_GET_DATA;
                S_GET_LINK: begin
                    if (!i_sts.rd_link_bad) r_state <= S_GET_RD;
                    else if (out_free) begin
                        r_ov <= 1'b1; r_status <= ST_BROKEN; r_data <= '0;
                        r_last <= 1'b1; r_state <= S_IDLE;
                    end
                end
                S_GET_DATA: begin
                    if (out_free) begin
                        r_ov <= 1'b1; r_status <= ST_OK; r_data <= i_rd_data;
                        r_last <= 1'b1; r_state <= S_IDLE;
                    end
                end
                S_PK_CHK: begin
                    if (!i_sts.ch_valid || i_sts.cur_done || i_sts.cur_end)
                        r_state <= S_OUT;
                    else if (i_sts.cur_at_link) r_state <= S_PK_LINK;
                    else r_state <= S_PK_DATA;
                end
                S_PK_LINK: r_state <= i_sts.rd_link_bad ? S_OUT : S_PK_CHK;
                S_PK_DATA: begin
                    // hold each byte back one step so the final one can carry last
                    if (out_free) begin
                        if (r_pk_more) begin
                            r_ov <= 1'b1; r_status <= ST_OK; r_data <= r_pk_byte;
                            r_last <= 1'b0;
                        end
                        r_pk_byte <= i_rd_data;
                        r_pk_more <= 1'b1;
                        r_state   <= S_PK_CHK;
                    end
                end
                S_OUT: begin
                    // end of peek: held byte goes out as last, or a single empty result
                    if (out_free) begin
                        r_ov <= 1'b1; r_last <= 1'b1;
                        r_pk_more <= 1'b0; r_state <= S_IDLE;
                        if (r_pk_more) begin
                            r_status <= ST_OK;
                            r_data   <= r_pk_byte;
                        end else begin
                            r_status <= i_sts.want_zero ? ST_OK : ST_EMPTY;
                            r_data   <= '0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `LBCF_ASSERT(a_out_hold, i_clk, i_rst_n,
        (r_ov && i_stall) |=> (r_ov && $stable(r_data) && $stable(r_last)),
        "result changed under stall")
    `LBCF_ASSERT(a_idle_take, i_clk, i_rst_n, (r_state == S_IDLE) |-> !o_stall, "idle yet stalling")
    `LBCF_ASSERT(a_peek_held, i_clk, i_rst_n, (r_state == S_IDLE) |-> !r_pk_more,
        "peek byte left behind")
endmodule

>>> src/linked_block_channel_fifo_unit.sv
// linked block channel fifo: byte channels sharing a pool of linked blocks
// flow: put claims or links a new block when needed before writing the byte;
// get and peek read bytes and follow links; output stalls hold the controller
// throughput: one command at a time; each byte costs one pool port access; block
// boundaries add link reads, or two link writes for put, on the single-port pool
// reset: synchronous active low; all blocks free, channels empty, limit 65535
module linked_block_channel_fifo_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [1:0]  i_channel,
    input  logic [7:0]  i_data_in,
    input  logic [15:0] i_limit,
    input  logic [4:0]  i_peek_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_data_out,
    output logic        o_last
);
    import lbcf_pkg::*;

    // command and status between controller and datapath
    t_cmd       cmd;
    t_sts       sts;
    logic [7:0] rd_data;
    logic [4:0] peek_n;

    lbcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .o_data_out (o_data_out),
        .o_last     (o_last),
        .o_cmd      (cmd),
        .i_sts      (sts),
        .i_rd_data  (rd_data)
    );

    lbcf_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_command    (i_command),
        .i_channel    (i_channel),
        .i_data_in    (i_data_in),
        .i_limit      (i_limit),
        .i_peek_count (i_peek_count),
        .o_rd_data    (rd_data),
        .o_peek_n     (peek_n)
    );

    // peek transfers never exceed the cap
    `LBCF_ASSERT(a_peek_cap, i_clk, i_rst_n, peek_n <= 5'(PEEK_MAX), "peek ran past cap")
endmodule
